>>> rtl/core/arst_pkg.sv
// ----------------------------------------------------------------------------
// arst_pkg
// Shared types, codes and defaults of the address range segment table.
// ----------------------------------------------------------------------------
package arst_pkg;

	localparam int ADDR_BITS        = 48;
	localparam int SEGMENTS_DEF     = 32;
	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int CFG_IDX_BITS     = 2;
	localparam int ATTR_BITS        = 7;
	localparam logic [ADDR_BITS-1:0] SPACE_START_RST = 48'h0000_0000_1000;
	localparam logic [ADDR_BITS-1:0] SPACE_END_RST   = 48'h8000_0000_0000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SPACE_START = 2'd0,
		CFG_SPACE_END   = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_UNMAP = 2'd1,
		OP_FAULT = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [ADDR_BITS-1:0] address;
		logic [ADDR_BITS-1:0] length;
		logic                 fixed_place;
		logic                 direct_map;
		logic [2:0]           protection;
		logic [1:0]           cache_mode;
		logic                 zero_fill;
		logic [ADDR_BITS-1:0] physical_base;
		logic                 not_present;
	} req_word_t;

	typedef struct packed {
		logic                 ok;
		logic                 table_full;
		logic [ADDR_BITS-1:0] result_address;
		logic                 hit_direct;
		logic [2:0]           hit_protection;
		logic [1:0]           hit_cache_mode;
		logic                 hit_zero_fill;
		logic [ADDR_BITS-1:0] physical_page;
	} rsp_word_t;

	typedef enum logic [1:0] {
		CUR_HOLD,
		CUR_ROUND,
		CUR_START,
		CUR_SEGEND
	} cur_cmd_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_NEW,
		WR_HEAD,
		WR_TAILCUT,
		WR_SPLIT_TAIL,
		WR_DEL
	} wr_cmd_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_MAP,
		RES_FULL,
		RES_OK,
		RES_FAULT
	} res_cmd_t;

	typedef struct packed {
		logic     load;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd;
		logic     slot_set;
		logic     nohint_set;
		logic     end_set;
		logic     out_load;
		cur_cmd_t cur;
		wr_cmd_t  wr;
		res_cmd_t res;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic fixed;
		logic not_present;
		logic len_zero;
		logic len_unal;
		logic addr_unal;
		logic nohint;
		logic fits;
		logic in_rng;
		logic chk_bad;
		logic ovl;
		logic split;
		logic cut;
		logic cut_head;
		logic cut_tail;
		logic hold;
		logic free;
		logic last;
		logic done_chk;
		logic fix_miss;
	} dp_stat_t;

endpackage

>>> rtl/core/address_range_segment_table.sv
// Fault: at most one table walk; check and map repeat a table walk up to SEGMENTS+1 times.
// Unmap: two walks plus a free-entry search in the worst case.
// Throughput: one word at a time; the single-port segment memory sets the pace.
// Reset: table empty (valid bits cleared at once), space registers to defaults.
// ----------------------------------------------------------------------------
// address_range_segment_table
// First-fit address range segment table with map, unmap, fault and check.
// ----------------------------------------------------------------------------
module address_range_segment_table #(
	parameter int SEGMENTS   = arst_pkg::SEGMENTS_DEF,
	parameter int PAGE_BYTES = arst_pkg::PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  arst_pkg::req_word_t               req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output arst_pkg::rsp_word_t               rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [arst_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [arst_pkg::ADDR_BITS-1:0]    cfg_data
);
	import arst_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	assign cfg_ready = 1'b1;

	arst_ctrl #(
		.SEGMENTS(SEGMENTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.st       (st),
		.cmd      (cmd)
	);

	arst_datapath #(
		.SEGMENTS  (SEGMENTS),
		.PAGE_BYTES(PAGE_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

>>> rtl/core/arst_datapath.sv
// ----------------------------------------------------------------------------
// arst_datapath
// Segment memory, valid bits, scan index, working addresses and result words.
// ----------------------------------------------------------------------------
module arst_datapath #(
	parameter int SEGMENTS   = arst_pkg::SEGMENTS_DEF,
	parameter int PAGE_BYTES = arst_pkg::PAGE_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  arst_pkg::req_word_t                 req,
	output arst_pkg::rsp_word_t                 rsp,
	input  logic                                cfg_we,
	input  logic [arst_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [arst_pkg::ADDR_BITS-1:0]      cfg_data,
	input  arst_pkg::dp_cmd_t                   cmd,
	output arst_pkg::dp_stat_t                  st
);
	import arst_pkg::*;

	localparam int AW = ADDR_BITS;
	localparam int XW = ADDR_BITS + 2;
	localparam int IW = $clog2(SEGMENTS);
	localparam logic [AW-1:0] PG_MASK = AW'(PAGE_BYTES - 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SEGMENTS - 1);

	typedef struct packed {
		logic [AW-1:0]        base;
		logic [AW-1:0]        length;
		logic [ATTR_BITS-1:0] attr;
		logic [AW-1:0]        phys;
	} entry_t;

	entry_t              mem_q [SEGMENTS];
	logic [SEGMENTS-1:0] valid_q;
	entry_t              rd_q;
	logic                rv_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       slot_q;
	logic [XW-1:0]       cur_q;
	logic [XW-1:0]       end_q;
	logic                nohint_q;
	req_word_t           item_q;
	rsp_word_t           res_q;
	rsp_word_t           rsp_q;
	logic [AW-1:0]       ss_q;
	logic [AW-1:0]       se_q;

	logic [XW-1:0] len_x, ss_x, se_x, s_x, t_x, sum_x, round_x;
	logic [AW-1:0] page, dphys;
	entry_t        wdata;
	logic [IW-1:0] waddr;
	logic          direct;

	assign len_x   = XW'(item_q.length);
	assign ss_x    = XW'(ss_q);
	assign se_x    = XW'(se_q);
	assign s_x     = XW'(rd_q.base);
	assign t_x     = XW'(rd_q.base) + XW'(rd_q.length);
	assign sum_x   = cur_q + len_x;
	assign round_x = (cur_q | XW'(PG_MASK)) + XW'(1);
	assign page    = cur_q[AW-1:0] & ~PG_MASK;
	assign direct  = rd_q.attr[0];
	assign dphys   = rd_q.phys + (end_q[AW-1:0] - rd_q.base);

	always_comb begin
		st.op          = item_q.op;
		st.fixed       = item_q.fixed_place;
		st.not_present = item_q.not_present;
		st.len_zero    = item_q.length == '0;
		st.len_unal    = (item_q.length & PG_MASK) != '0;
		st.addr_unal   = (cur_q[AW-1:0] & PG_MASK) != '0;
		st.nohint      = nohint_q;
		st.in_rng      = cur_q >= ss_x && cur_q < se_x;
		st.fits        = st.in_rng && (se_x - cur_q) >= len_x;
		st.chk_bad     = !st.in_rng || sum_x[XW-1:AW] != '0 || sum_x < ss_x || sum_x >= se_x;
		st.ovl         = rv_q && cur_q < t_x && s_x < sum_x;
		st.split       = rv_q && s_x < cur_q && t_x > end_q;
		st.cut         = rv_q && t_x > cur_q && s_x < end_q;
		st.cut_head    = s_x < cur_q;
		st.cut_tail    = t_x > end_q;
		st.hold        = rv_q && cur_q >= s_x && (cur_q - s_x) < XW'(rd_q.length);
		st.free        = !valid_q[idx_q];
		st.last        = idx_q == LAST_IDX;
		st.done_chk    = cur_q >= end_q;
		st.fix_miss    = cur_q != XW'(item_q.address);
	end

	always_comb begin
		wdata = rd_q;
		waddr = idx_q;
		case (cmd.wr)
			WR_NEW: begin
				waddr       = slot_q;
				wdata.base  = cur_q[AW-1:0];
				wdata.length = item_q.length;
				wdata.attr  = {item_q.zero_fill & ~item_q.direct_map, item_q.cache_mode,
					item_q.protection, item_q.direct_map};
				wdata.phys  = item_q.direct_map ? item_q.physical_base : '0;
			end
			WR_HEAD: begin
				wdata.length = cur_q[AW-1:0] - rd_q.base;
			end
			WR_TAILCUT: begin
				wdata.base   = end_q[AW-1:0];
				wdata.length = AW'(t_x - end_q);
				wdata.phys   = direct ? dphys : rd_q.phys;
			end
			WR_SPLIT_TAIL: begin
				waddr        = slot_q;
				wdata.base   = end_q[AW-1:0];
				wdata.length = AW'(t_x - end_q);
				wdata.phys   = direct ? dphys : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr != WR_NONE && cmd.wr != WR_DEL) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[idx_q];
		end
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.slot_set) begin
			slot_q <= idx_q;
		end
		if (cmd.end_set) begin
			end_q <= sum_x;
		end
		if (cmd.nohint_set) begin
			nohint_q <= st.addr_unal && round_x[XW-1:AW] != '0;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q    <= 1'b0;
			idx_q   <= '0;
			cur_q   <= '0;
			res_q   <= '0;
			ss_q    <= SPACE_START_RST;
			se_q    <= SPACE_END_RST;
		end else begin
			if (cfg_we && cfg_index == CFG_SPACE_START) begin
				ss_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_SPACE_END) begin
				se_q <= cfg_data;
			end
			if (cmd.wr == WR_NEW || cmd.wr == WR_SPLIT_TAIL) begin
				valid_q[slot_q] <= 1'b1;
			end
			if (cmd.wr == WR_DEL) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (cmd.rd) begin
				rv_q <= valid_q[idx_q];
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.load) begin
				cur_q <= XW'(req.address);
			end else begin
				case (cmd.cur)
					CUR_ROUND:  cur_q <= st.addr_unal ? round_x : cur_q;
					CUR_START:  cur_q <= ss_x;
					CUR_SEGEND: cur_q <= t_x;
					default:    cur_q <= cur_q;
				endcase
			end
			if (cmd.load) begin
				res_q <= '0;
			end else begin
				case (cmd.res)
					RES_MAP: begin
						res_q.ok             <= 1'b1;
						res_q.result_address <= cur_q[AW-1:0];
					end
					RES_FULL: res_q.table_full <= 1'b1;
					RES_OK:   res_q.ok         <= 1'b1;
					RES_FAULT: begin
						res_q.ok             <= 1'b1;
						res_q.result_address <= page;
						res_q.hit_direct     <= rd_q.attr[0];
						res_q.hit_protection <= rd_q.attr[3:1];
						res_q.hit_cache_mode <= rd_q.attr[5:4];
						res_q.hit_zero_fill  <= rd_q.attr[6];
						res_q.physical_page  <= direct ? rd_q.phys + (page - rd_q.base) : '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp = rsp_q;

endmodule

>>> rtl/core/arst_ctrl.sv
// ----------------------------------------------------------------------------
// arst_ctrl
// Sequencer: decodes a request word and walks the segment table.
// ----------------------------------------------------------------------------
module arst_ctrl #(
	parameter int SEGMENTS = arst_pkg::SEGMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  arst_pkg::dp_stat_t st,
	output arst_pkg::dp_cmd_t  cmd
);
	import arst_pkg::*;

	localparam int PW = $clog2(SEGMENTS + 2);
	localparam logic [PW-1:0] PASS_LIM = PW'(SEGMENTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_FREE, S_MSTART, S_MPASS, S_MFIN,
		S_RD, S_EV, S_TAIL, S_CLOOP, S_RESP
	} state_t;

	typedef enum logic [1:0] {
		SC_MAP, SC_SPL, SC_CUT, SC_HOLD
	} mode_t;

	state_t        state_q, state_d;
	mode_t         mode_q, mode_d;
	logic [PW-1:0] pass_q;
	logic          pass_clr, pass_inc;
	logic          rsp_valid_q;

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		mode_d   = mode_q;
		pass_clr = 1'b0;
		pass_inc = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_RESP;
				case (st.op)
					OP_MAP: begin
						if (!(st.len_zero || st.len_unal || (st.addr_unal && st.fixed))) begin
							cmd.nohint_set = 1'b1;
							cmd.cur        = CUR_ROUND;
							cmd.idx_clr    = 1'b1;
							state_d        = S_FREE;
						end
					end
					OP_UNMAP: begin
						if (st.len_zero) begin
							cmd.res = RES_OK;
						end else if (!(st.addr_unal || st.len_unal || !st.fits)) begin
							cmd.end_set = 1'b1;
							cmd.idx_clr = 1'b1;
							mode_d      = SC_SPL;
							state_d     = S_RD;
						end
					end
					OP_FAULT: begin
						if (st.not_present && st.in_rng) begin
							cmd.idx_clr = 1'b1;
							mode_d      = SC_HOLD;
							state_d     = S_RD;
						end
					end
					default: begin
						if (!st.chk_bad) begin
							cmd.end_set = 1'b1;
							pass_clr    = 1'b1;
							state_d     = S_CLOOP;
						end
					end
				endcase
			end
			S_FREE: begin
				if (st.free) begin
					cmd.slot_set = 1'b1;
					if (st.op == OP_MAP) begin
						state_d = S_MSTART;
					end else begin
						cmd.idx_clr = 1'b1;
						mode_d      = SC_CUT;
						state_d     = S_RD;
					end
				end else if (st.last) begin
					cmd.res = RES_FULL;
					state_d = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_MSTART: begin
				if (st.nohint || !st.fits) begin
					cmd.cur = CUR_START;
				end
				pass_clr = 1'b1;
				state_d  = S_MPASS;
			end
			S_MPASS: begin
				if (pass_q == PASS_LIM || !st.fits) begin
					state_d = S_RESP;
				end else begin
					cmd.idx_clr = 1'b1;
					mode_d      = SC_MAP;
					state_d     = S_RD;
				end
			end
			S_MFIN: begin
				if (!(st.fixed && st.fix_miss)) begin
					cmd.wr  = WR_NEW;
					cmd.res = RES_MAP;
				end
				state_d = S_RESP;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				case (mode_q)
					SC_MAP: begin
						if (st.ovl) begin
							cmd.cur  = CUR_SEGEND;
							pass_inc = 1'b1;
							state_d  = S_MPASS;
						end else if (st.last) begin
							state_d = S_MFIN;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_RD;
						end
					end
					SC_SPL: begin
						if (st.split) begin
							cmd.idx_clr = 1'b1;
							state_d     = S_FREE;
						end else if (st.last) begin
							cmd.idx_clr = 1'b1;
							mode_d      = SC_CUT;
							state_d     = S_RD;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_RD;
						end
					end
					SC_CUT: begin
						if (st.cut && st.cut_head && st.cut_tail) begin
							cmd.wr  = WR_HEAD;
							state_d = S_TAIL;
						end else begin
							if (st.cut) begin
								cmd.wr = st.cut_head ? WR_HEAD : (st.cut_tail ? WR_TAILCUT : WR_DEL);
							end
							if (st.last) begin
								cmd.res = RES_OK;
								state_d = S_RESP;
							end else begin
								cmd.idx_inc = 1'b1;
								state_d     = S_RD;
							end
						end
					end
					default: begin
						if (st.hold) begin
							if (st.op == OP_FAULT) begin
								cmd.res = RES_FAULT;
								state_d = S_RESP;
							end else begin
								cmd.cur  = CUR_SEGEND;
								pass_inc = 1'b1;
								state_d  = S_CLOOP;
							end
						end else if (st.last) begin
							state_d = S_RESP;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_RD;
						end
					end
				endcase
			end
			S_TAIL: begin
				cmd.wr = WR_SPLIT_TAIL;
				if (st.last) begin
					cmd.res = RES_OK;
					state_d = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_CLOOP: begin
				if (pass_q == PASS_LIM) begin
					state_d = S_RESP;
				end else if (st.done_chk) begin
					cmd.res = RES_OK;
					state_d = S_RESP;
				end else if (!st.in_rng) begin
					state_d = S_RESP;
				end else begin
					cmd.idx_clr = 1'b1;
					mode_d      = SC_HOLD;
					state_d     = S_RD;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= SC_MAP;
			pass_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (pass_clr) begin
				pass_q <= '0;
			end else if (pass_inc) begin
				pass_q <= pass_q + PW'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> tb/address_range_segment_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// address_range_segment_table_test
// Self-checking bench: a directed table, then random map, unmap, fault and
// check traffic over several address space settings, scored word by word
// against an in-bench segment table model.
// ----------------------------------------------------------------------------
module address_range_segment_table_test;
	import arst_pkg::*;

	localparam int NSEG = SEGMENTS_DEF;
	localparam logic [63:0] PG = PAGE_BYTES_DEF;
	localparam logic [63:0] AM = 64'h0000_FFFF_FFFF_FFFF;
	localparam int IDLE_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_word_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [ADDR_BITS-1:0] cfg_data = '0;

	address_range_segment_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// segment table model
	logic        seg_on[NSEG];
	logic [63:0] seg_lo[NSEG];
	logic [63:0] seg_len[NSEG];
	logic [63:0] seg_phys[NSEG];
	logic        seg_dir[NSEG];
	logic [2:0]  seg_prot[NSEG];
	logic [1:0]  seg_cmode[NSEG];
	logic        seg_zero[NSEG];
	logic [63:0] sp_lo = 64'(SPACE_START_RST);
	logic [63:0] sp_hi = 64'(SPACE_END_RST);

	rsp_word_t want_q[$];
	int err_cnt = 0;
	int words_in = 0;
	int words_out = 0;
	int ok_cnt = 0;
	int full_cnt = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int cyc = 0;

	function automatic logic fits_space(logic [63:0] a, logic [63:0] len);
		return a >= sp_lo && a < sp_hi && (sp_hi - a) >= len;
	endfunction

	function automatic int first_free();
		for (int i = 0; i < NSEG; i++)
			if (!seg_on[i]) return i;
		return -1;
	endfunction

	function automatic int holder_of(logic [63:0] a);
		if (a < sp_lo || a >= sp_hi) return -1;
		for (int i = 0; i < NSEG; i++)
			if (seg_on[i] && a >= seg_lo[i] && a - seg_lo[i] < seg_len[i]) return i;
		return -1;
	endfunction

	function automatic rsp_word_t map_range(req_word_t w);
		rsp_word_t r;
		logic [63:0] hint, len, a, add;
		logic use_hint, found, hit;
		int slot;
		r = '0;
		hint = 64'(w.address);
		len = 64'(w.length);
		a = hint;
		use_hint = 1'b1;
		found = 1'b0;
		if (len == 0 || len % PG != 0) return r;
		if (a % PG != 0) begin
			add = PG - a % PG;
			if (w.fixed_place) return r;
			if (a > AM - add) use_hint = 1'b0;
			else a = a + add;
		end
		slot = first_free();
		if (slot < 0) begin
			r.table_full = 1'b1;
			return r;
		end
		if (!use_hint || !fits_space(a, len)) a = sp_lo;
		for (int n = 0; n <= NSEG && !found; n++) begin
			if (!fits_space(a, len)) return r;
			hit = 1'b0;
			for (int i = 0; i < NSEG && !hit; i++)
				if (seg_on[i] && a < seg_lo[i] + seg_len[i] && seg_lo[i] < a + len) begin
					a = seg_lo[i] + seg_len[i];
					hit = 1'b1;
				end
			if (!hit) found = 1'b1;
		end
		if (!found) return r;
		if (w.fixed_place && a != hint) return r;
		seg_on[slot] = 1'b1;
		seg_lo[slot] = a;
		seg_len[slot] = len;
		seg_dir[slot] = w.direct_map;
		seg_prot[slot] = w.protection;
		seg_cmode[slot] = w.cache_mode;
		seg_zero[slot] = !w.direct_map && w.zero_fill;
		seg_phys[slot] = w.direct_map ? 64'(w.physical_base) : 64'd0;
		r.ok = 1'b1;
		r.result_address = a[47:0];
		return r;
	endfunction

	function automatic rsp_word_t unmap_range(req_word_t w);
		rsp_word_t r;
		logic [63:0] a, len, e, s, t;
		logic need_split;
		int slot;
		r = '0;
		a = 64'(w.address);
		len = 64'(w.length);
		slot = -1;
		need_split = 1'b0;
		if (len == 0) begin
			r.ok = 1'b1;
			return r;
		end
		if (a % PG != 0 || len % PG != 0 || !fits_space(a, len)) return r;
		e = a + len;
		for (int i = 0; i < NSEG; i++)
			if (seg_on[i] && seg_lo[i] < a && seg_lo[i] + seg_len[i] > e) need_split = 1'b1;
		if (need_split) begin
			slot = first_free();
			if (slot < 0) begin
				r.table_full = 1'b1;
				return r;
			end
		end
		for (int i = 0; i < NSEG; i++) begin
			if (!seg_on[i]) continue;
			s = seg_lo[i];
			t = s + seg_len[i];
			if (t <= a || s >= e) continue;
			if (s < a && t > e) begin
				seg_on[slot] = 1'b1;
				seg_lo[slot] = e;
				seg_len[slot] = t - e;
				seg_dir[slot] = seg_dir[i];
				seg_prot[slot] = seg_prot[i];
				seg_cmode[slot] = seg_cmode[i];
				seg_zero[slot] = seg_zero[i];
				seg_phys[slot] = seg_dir[i] ? ((seg_phys[i] + (e - s)) & AM) : 64'd0;
				seg_len[i] = a - s;
			end else if (s < a) begin
				seg_len[i] = a - s;
			end else if (t > e) begin
				seg_lo[i] = e;
				seg_len[i] = t - e;
				if (seg_dir[i]) seg_phys[i] = (seg_phys[i] + (e - s)) & AM;
			end else begin
				seg_on[i] = 1'b0;
			end
		end
		r.ok = 1'b1;
		return r;
	endfunction

	function automatic rsp_word_t fault_lookup(req_word_t w);
		rsp_word_t r;
		logic [63:0] a, pg_a;
		int i;
		r = '0;
		a = 64'(w.address);
		if (!w.not_present) return r;
		i = holder_of(a);
		if (i < 0) return r;
		pg_a = a - a % PG;
		r.ok = 1'b1;
		r.result_address = pg_a[47:0];
		r.hit_direct = seg_dir[i];
		r.hit_protection = seg_prot[i];
		r.hit_cache_mode = seg_cmode[i];
		r.hit_zero_fill = seg_zero[i];
		if (seg_dir[i]) r.physical_page = 48'((seg_phys[i] + (pg_a - seg_lo[i])) & AM);
		return r;
	endfunction

	function automatic rsp_word_t range_covered(req_word_t w);
		rsp_word_t r;
		logic [63:0] a, len, e;
		int i;
		r = '0;
		a = 64'(w.address);
		len = 64'(w.length);
		if (a < sp_lo || a >= sp_hi) return r;
		if (len > AM - a) return r;
		e = a + len;
		if (e < sp_lo || e >= sp_hi) return r;
		for (int n = 0; n <= NSEG; n++) begin
			if (a >= e) begin
				r.ok = 1'b1;
				return r;
			end
			i = holder_of(a);
			if (i < 0) return r;
			a = seg_lo[i] + seg_len[i];
		end
		return r;
	endfunction

	function automatic rsp_word_t segment_table_outcome(req_word_t w);
		case (w.op)
			OP_MAP:   return map_range(w);
			OP_UNMAP: return unmap_range(w);
			OP_FAULT: return fault_lookup(w);
			default:  return range_covered(w);
		endcase
	endfunction

	function automatic req_word_t mk(op_t op, logic [63:0] addr, logic [63:0] len,
			logic fx, logic dm, logic [2:0] pr, logic [1:0] cm, logic zf,
			logic [63:0] phys, logic np);
		req_word_t w;
		w.op = op;
		w.address = addr[47:0];
		w.length = len[47:0];
		w.fixed_place = fx;
		w.direct_map = dm;
		w.protection = pr;
		w.cache_mode = cm;
		w.zero_fill = zf;
		w.physical_base = phys[47:0];
		w.not_present = np;
		return w;
	endfunction

	function automatic logic [63:0] rnd48();
		return {$urandom(), $urandom()} & AM;
	endfunction

	// mostly well-formed traffic around a window; the rest is noise
	function automatic req_word_t rand_word(logic [63:0] win);
		req_word_t w;
		int pick;
		logic [63:0] a, len;
		w = mk(op_t'($urandom_range(0, 3)), rnd48(), rnd48(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), rnd48(), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 9) < 2) return w;
		pick = $urandom_range(0, 99);
		w.op = pick < 35 ? OP_MAP : pick < 55 ? OP_UNMAP : pick < 80 ? OP_FAULT : OP_CHECK;
		a = (win + 64'($urandom_range(0, 80)) * PG) & AM;
		len = 64'($urandom_range(1, 10)) * PG;
		if (w.op == OP_FAULT) a = (a + 64'($urandom_range(0, 4095))) & AM;
		if (w.op != OP_MAP && $urandom_range(0, 15) == 0) len = 0;
		w.address = a[47:0];
		w.length = len[47:0];
		w.fixed_place = $urandom_range(0, 3) == 0;
		w.not_present = $urandom_range(0, 6) != 0;
		return w;
	endfunction

	task automatic send_word(req_word_t w, logic typed, rsp_word_t want);
		rsp_word_t got;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		got = segment_table_outcome(w);
		want_q.push_back(typed ? want : got);
		words_in++;
		burst_left--;
	endtask

	task automatic settle();
		if (req_valid) req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (want_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val[47:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SPACE_START) sp_lo = val & AM;
		else sp_hi = val & AM;
	endtask

	task automatic random_run(int n, logic [63:0] win);
		for (int k = 0; k < n; k++) send_word(rand_word(win), 1'b0, '0);
	endtask

	task automatic check_word(rsp_word_t want, rsp_word_t got);
		if (got.ok !== want.ok) begin
			$error("ok exp %0h got %0h", want.ok, got.ok);
			err_cnt++;
		end
		if (got.table_full !== want.table_full) begin
			$error("table_full exp %0h got %0h", want.table_full, got.table_full);
			err_cnt++;
		end
		if (got.result_address !== want.result_address) begin
			$error("result_address exp %0h got %0h", want.result_address, got.result_address);
			err_cnt++;
		end
		if (got.hit_direct !== want.hit_direct) begin
			$error("hit_direct exp %0h got %0h", want.hit_direct, got.hit_direct);
			err_cnt++;
		end
		if (got.hit_protection !== want.hit_protection) begin
			$error("hit_protection exp %0h got %0h", want.hit_protection, got.hit_protection);
			err_cnt++;
		end
		if (got.hit_cache_mode !== want.hit_cache_mode) begin
			$error("hit_cache_mode exp %0h got %0h", want.hit_cache_mode, got.hit_cache_mode);
			err_cnt++;
		end
		if (got.hit_zero_fill !== want.hit_zero_fill) begin
			$error("hit_zero_fill exp %0h got %0h", want.hit_zero_fill, got.hit_zero_fill);
			err_cnt++;
		end
		if (got.physical_page !== want.physical_page) begin
			$error("physical_page exp %0h got %0h", want.physical_page, got.physical_page);
			err_cnt++;
		end
	endtask

	// receiver: free-running stretches alternate with random stalls
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc[9]) rsp_ready <= 1'b1;
		else if (cyc[6]) rsp_ready <= $urandom_range(0, 3) != 0;
		else rsp_ready <= $urandom_range(0, 7) == 0;
		if (arst_n && rsp_valid && rsp_ready) begin
			words_out++;
			if (rsp.ok) ok_cnt++;
			if (rsp.table_full) full_cnt++;
			if (want_q.size() == 0) begin
				$error("unexpected response word");
				err_cnt++;
			end else begin
				check_word(want_q.pop_front(), rsp);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	typedef struct {
		req_word_t w;
		logic      typed;
		rsp_word_t want;
	} stim_row_t;

	stim_row_t rows[$];

	task automatic add_row(req_word_t w, logic typed, rsp_word_t want);
		stim_row_t r;
		r.w = w;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	initial begin
		rsp_word_t z, okw;
		z = '0;
		okw = '0;
		okw.ok = 1'b1;
		for (int i = 0; i < NSEG; i++) begin
			seg_on[i] = 1'b0;
			seg_lo[i] = 0;
			seg_len[i] = 0;
			seg_phys[i] = 0;
			seg_dir[i] = 0;
			seg_prot[i] = 0;
			seg_cmode[i] = 0;
			seg_zero[i] = 0;
		end

		// empty table and bad arguments, then a first fixed map
		add_row(mk(OP_FAULT, 64'h1_0000, 0, 0, 0, 0, 0, 0, 0, 1), 1, z);
		add_row(mk(OP_MAP, 64'h1_0000, 0, 0, 0, 7, 3, 1, 0, 0), 1, z);
		add_row(mk(OP_MAP, 64'h1_0000, 64'h1800, 0, 0, 7, 3, 1, 0, 0), 1, z);
		add_row(mk(OP_MAP, 64'h1_0010, 64'h1000, 1, 0, 7, 3, 1, 0, 0), 1, z);
		add_row(mk(OP_CHECK, 64'h0, 64'h1000, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_UNMAP, 64'h1_0000, 0, 0, 0, 0, 0, 0, 0, 0), 1, okw);
		okw.result_address = 48'h1_0000;
		add_row(mk(OP_MAP, 64'h1_0000, 64'h1000, 1, 0, 5, 2, 1, AM, 0), 1, okw);
		// occupied fixed hint, rounded hint, hint rounding past the top
		add_row(mk(OP_MAP, 64'h1_0000, 64'h1000, 1, 0, 1, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_MAP, 64'h1_0001, 64'h4000, 0, 1, 3, 1, 1, 64'hABC_0000_0000, 0), 0, z);
		add_row(mk(OP_MAP, AM - 5, 64'h2000, 0, 0, 6, 3, 1, 0, 0), 0, z);
		add_row(mk(OP_MAP, 64'h0, AM - 64'hFFF, 0, 1, 7, 3, 0, AM, 0), 0, z);
		add_row(mk(OP_FAULT, 64'h1_2345, 0, 0, 0, 0, 0, 0, 0, 1), 0, z);
		add_row(mk(OP_FAULT, 64'h1_2345, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_CHECK, 64'h1_0000, 64'h5000, 0, 0, 0, 0, 0, 0, 0), 0, z);
		// split a direct segment, then look at the tail
		add_row(mk(OP_UNMAP, 64'h1_2000, 64'h1000, 0, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(OP_FAULT, 64'h1_3FFF, 0, 0, 0, 0, 0, 0, 0, 1), 0, z);
		add_row(mk(OP_CHECK, 64'h1_0000, 64'h5000, 0, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(OP_UNMAP, 64'h1_0800, 64'h1000, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_UNMAP, 64'h0, 64'h1000, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_CHECK, 64'h7FFF_FFFF_F000, 64'h1000, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_CHECK, 64'h2_0000, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(OP_CHECK, AM, AM, 1, 1, 7, 3, 1, AM, 1), 1, z);
		add_row(mk(OP_FAULT, AM, AM, 1, 1, 7, 3, 1, AM, 1), 1, z);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
		random_run(400, 64'h1_0000);
		settle();

		// tiny space from zero: fill the table, split with no free entry
		write_reg(CFG_SPACE_START, 64'h0);
		write_reg(CFG_SPACE_END, 64'h4_0000);
		send_word(mk(OP_MAP, 64'h0, 64'h3000, 0, 1, 3, 1, 0, 64'h5000, 0), 0, z);
		for (int k = 0; k < NSEG; k++)
			send_word(mk(OP_MAP, 64'h0, 64'h1000, 0, 0, 1, 2, 1, 0, 0), 0, z);
		send_word(mk(OP_UNMAP, 64'h1000, 64'h1000, 0, 0, 0, 0, 0, 0, 0), 0, z);
		random_run(400, 64'h0);
		settle();

		// unaligned space start
		write_reg(CFG_SPACE_START, 64'h1800);
		write_reg(CFG_SPACE_END, 64'h3_0000);
		random_run(400, 64'h0);
		settle();

		// whole address range
		write_reg(CFG_SPACE_START, 64'h0);
		write_reg(CFG_SPACE_END, AM);
		random_run(200, 64'h0);
		random_run(200, AM + 1 - 64'd60 * PG);
		settle();

		// degenerate space at the very top
		write_reg(CFG_SPACE_START, AM);
		write_reg(CFG_SPACE_END, AM);
		random_run(20, AM + 1 - 64'd40 * PG);
		settle();

		repeat (50) @(posedge clk);
		$display("%0d request words, %0d response words (%0d ok, %0d table full)",
			words_in, words_out, ok_cnt, full_cnt);
		$display("five address space settings, including both extremes");
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> address_range_segment_table.f
rtl/core/arst_pkg.sv
rtl/core/arst_datapath.sv
rtl/core/arst_ctrl.sv
rtl/core/address_range_segment_table.sv
tb/address_range_segment_table_test.sv
